FILE: rtl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared constants and codes for the region bitmap placement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbp_pkg;

  // Default configuration of the block.
  localparam int NUM_REGIONS_DEF         = 4;
  localparam int GRANULES_PER_REGION_DEF = 4096;
  localparam int GRANULE_BYTES_DEF       = 4;

  // Occupancy memory word.
  localparam int WORD_BITS = 32;
  localparam int WORD_LSB  = 5;

  // Width of internal address arithmetic (covers 2^32 plus carries).
  localparam int AXW = 34;

  // Request modes.
  localparam logic [1:0] MODE_DEFINE = 2'd0;
  localparam logic [1:0] MODE_STATIC = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/rbp_ram.sv
// ----------------------------------------------------------------------------
// rbp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rbp_div.sv
// ----------------------------------------------------------------------------
// rbp_div
// Division of an unsigned value by a fixed divisor through a reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The quotient is exact for every numerator up to MAXNUM. It is ready when
// done pulses for one cycle.
module rbp_div #(
  parameter int DIVISOR = 4,
  parameter int NW      = 34,
  parameter int MAXNUM  = 16384
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  output logic               done,
  output logic      [NW-1:0] quo
);

  localparam int     NB    = $clog2(MAXNUM + 1);
  localparam int     SH    = NB + $clog2(DIVISOR);
  localparam int     MW    = NB + 2;
  localparam int     PW    = NB + MW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) /
                             longint'(DIVISOR);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic [PW-1:0] prod;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
      if (start) begin
        prod <= PW'(num[NB-1:0]) * PW'(RECIP_M);
      end
      if (busy) begin
        quo <= NW'(prod >> SH);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/region_bitmap_placement.sv
// ----------------------------------------------------------------------------
// region_bitmap_placement
// First-fit placement over a table of regions with per-granule bitmaps.
// ----------------------------------------------------------------------------
// Each input item yields exactly one result item, and items are handled one
// at a time. After reset the block sweeps the occupancy memory to zero, one
// 32-bit word per cycle, and takes no item until that is done. The time of a
// define is set by the read-modify-write clear of the region's words. Static
// placement looks at the regions in turn, then runs two divisions by the
// granule size and a read and a write for each marked word. Automatic
// placement takes a find and a check step per region tried, two divisions
// per region entered, a step per granule examined plus a load per memory
// word, and two jump steps and a division for each occupied granule that
// forces a jump to the next aligned candidate; marking the winner takes a
// read and a write per word. The division by the granule size and the
// one-word-per-cycle access to the occupancy memory set these costs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module region_bitmap_placement #(
  parameter int NUM_REGIONS         = rbp_pkg::NUM_REGIONS_DEF,
  parameter int GRANULES_PER_REGION = rbp_pkg::GRANULES_PER_REGION_DEF,
  parameter int GRANULE_BYTES       = rbp_pkg::GRANULE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request items.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // From bit 0: region_index[1:0], start_address[31:0], span_size[32:0],
  // attributes[5:0], align_log2[4:0], two zero bits.
  input  wire logic [79:0] s_tdata,
  // mode[1:0].
  input  wire logic [1:0]  s_tuser,
  // Result items.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // From bit 0: status[1:0], placed_address[31:0], six zero bits.
  output logic      [39:0] m_tdata
);

  import rbp_pkg::*;

  localparam int RIW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int GIW    = $clog2(GRANULES_PER_REGION + 1);
  localparam int TOTAL  = NUM_REGIONS * GRANULES_PER_REGION;
  localparam int FW     = $clog2(TOTAL + 1);
  localparam int WORDS  = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW     = ((AW + WORD_LSB) > FW) ? (AW + WORD_LSB) : FW;
  localparam int CAP    = GRANULES_PER_REGION * GRANULE_BYTES;

  typedef enum logic [15:0] {
    S_CLEAR      = 16'h0001,
    S_IDLE       = 16'h0002,
    S_STAT_FIND  = 16'h0004,
    S_AUTO_FIND  = 16'h0008,
    S_AUTO_CHK   = 16'h0010,
    S_DIVGO      = 16'h0020,
    S_DIV        = 16'h0040,
    S_CAND       = 16'h0080,
    S_SCAN       = 16'h0100,
    S_SCAN_LD    = 16'h0200,
    S_JUMP1      = 16'h0400,
    S_JUMP2      = 16'h0800,
    S_FILL_START = 16'h1000,
    S_FILL_RD    = 16'h2000,
    S_FILL_WR    = 16'h4000,
    S_RESP       = 16'h8000
  } state_t;

  // What the current division computes.
  typedef enum logic [3:0] {
    PH_STAT_BS = 4'b0001,
    PH_STAT_N  = 4'b0010,
    PH_AUTO_N  = 4'b0100,
    PH_AUTO_BS = 4'b1000
  } phase_t;

  state_t state;
  phase_t phase;

  // Region table.
  logic [31:0] base    [NUM_REGIONS];
  logic [32:0] len     [NUM_REGIONS];
  logic [5:0]  attr_tb [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] defined;

  // Latched request.
  logic [31:0] start_q;
  logic [32:0] size_q;
  logic [5:0]  attr_q;
  logic [4:0]  lg_q;

  // Search state.
  logic [RIW-1:0] r;
  logic [AXW-1:0] t, fs, fe, e_r, bs_q, prod;
  logic           region_ok;
  logic [GIW-1:0] n_g, p;

  // Fill sweep.
  logic [FW-1:0] fill_lo, fill_hi;
  logic          fill_v;
  logic [AW-1:0] widx, wlast, clr_addr;

  // Word buffer for the scan.
  logic [WORD_BITS-1:0] buf_word;
  logic [AW-1:0]        buf_addr;
  logic                 buf_ok;

  // Pending result.
  logic [1:0]  res_status;
  logic [31:0] res_addr;

  // Memory and divider hookups.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, fill_mask;
  logic                 div_start, div_done;
  logic [AXW-1:0]       div_num, div_q;

  // Derived values for the region under the cursor.
  logic [AXW-1:0]   cur_b, cur_len, cur_e, align_m1, req_end;
  logic             attr_ok;
  logic [FW-1:0]    off, flat;
  logic [AW-1:0]    flat_word;
  logic             buf_hit, cur_bit;
  logic [GIW:0]     win_end, stat_end;
  logic [GIW-1:0]   bs_g;
  logic [XW-1:0]    word_base;
  logic [1:0]       mode_in;
  logic [1:0]       idx_in;
  logic [31:0]      start_in;
  logic [32:0]      size_in;

  assign mode_in  = s_tuser;
  assign idx_in   = s_tdata[1:0];
  assign start_in = s_tdata[33:2];
  assign size_in  = s_tdata[66:34];

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cur_b     = AXW'(base[r]);
    cur_len   = AXW'(len[r]);
    cur_e     = cur_b + cur_len;
    align_m1  = (AXW'(1) << lg_q) - AXW'(1);
    req_end   = AXW'(start_q) + AXW'(size_q);
    attr_ok   = ((attr_tb[r] & attr_q) == attr_q);
    off       = FW'(r) * FW'(GRANULES_PER_REGION);
    bs_g      = GIW'(bs_q);
    flat      = off + FW'(p);
    flat_word = AW'(flat >> WORD_LSB);
    buf_hit   = buf_ok && (buf_addr == flat_word);
    cur_bit   = buf_word[flat[WORD_LSB-1:0]];
    win_end   = (GIW+1)'(bs_g) + (GIW+1)'(n_g);
    stat_end  = (GIW+1)'(bs_g) + (GIW+1)'(div_q);
    if (stat_end > (GIW+1)'(GRANULES_PER_REGION)) begin
      stat_end = (GIW+1)'(GRANULES_PER_REGION);
    end
  end

  // Per-bit mask of the fill range inside the current word.
  always_comb begin
    word_base = XW'(widx) << WORD_LSB;
    for (int j = 0; j < WORD_BITS; j++) begin
      fill_mask[j] = ((word_base + XW'(j)) >= XW'(fill_lo)) &&
                     ((word_base + XW'(j)) <  XW'(fill_hi));
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = (ram_rdata & ~fill_mask) | (fill_v ? fill_mask : '0);
    ram_raddr = (state == S_FILL_RD) ? widx : flat_word;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_FILL_WR) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    div_start = (state == S_DIVGO);
    case (phase)
      PH_STAT_BS: div_num = AXW'(start_q) - cur_b;
      PH_AUTO_BS: div_num = t - cur_b;
      default:    div_num = AXW'(size_q);
    endcase
  end

  rbp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_occ (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Each numerator is an offset or a size inside one region, so it does not
  // exceed the region capacity in bytes, unless a jump carried it past the end.
  rbp_div #(
    .DIVISOR (GRANULE_BYTES),
    .NW      (AXW),
    .MAXNUM  (CAP)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      phase    <= PH_STAT_BS;
      defined  <= '0;
      clr_addr <= '0;
      buf_ok   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_tvalid) begin
            start_q    <= start_in;
            size_q     <= size_in;
            attr_q     <= s_tdata[72:67];
            lg_q       <= s_tdata[77:73];
            r          <= '0;
            res_addr   <= '0;
            case (mode_in)
              MODE_DEFINE: begin
                if (32'(idx_in) >= NUM_REGIONS) begin
                  res_status <= ST_REJECT;
                  state      <= S_RESP;
                end else if (AXW'(size_in) > AXW'(CAP)) begin
                  defined[RIW'(idx_in)] <= 1'b0;
                  res_status <= ST_TOO_BIG;
                  state      <= S_RESP;
                end else if ((AXW'(start_in) + AXW'(size_in)) > (AXW'(1) << 32)) begin
                  defined[RIW'(idx_in)] <= 1'b0;
                  res_status <= ST_REJECT;
                  state      <= S_RESP;
                end else begin
                  base[RIW'(idx_in)]    <= start_in;
                  len[RIW'(idx_in)]     <= size_in;
                  attr_tb[RIW'(idx_in)] <= s_tdata[72:67];
                  defined[RIW'(idx_in)] <= 1'b1;
                  fill_lo    <= FW'(idx_in) * FW'(GRANULES_PER_REGION);
                  fill_hi    <= FW'(idx_in) * FW'(GRANULES_PER_REGION) +
                                FW'(GRANULES_PER_REGION);
                  fill_v     <= 1'b0;
                  res_status <= ST_OK;
                  state      <= S_FILL_START;
                end
              end
              MODE_STATIC: begin
                res_status <= ST_REJECT;
                state      <= S_STAT_FIND;
              end
              MODE_AUTO: begin
                res_status <= ST_REJECT;
                state      <= S_AUTO_FIND;
              end
              default: begin
                res_status <= ST_REJECT;
                state      <= S_RESP;
              end
            endcase
          end
        end

        S_STAT_FIND: begin
          if (defined[r] && (AXW'(start_q) >= cur_b) && (AXW'(start_q) < cur_e)) begin
            if ((req_end > cur_e) || !attr_ok) begin
              res_status <= ST_REJECT;
              state      <= S_RESP;
            end else begin
              phase <= PH_STAT_BS;
              state <= S_DIVGO;
            end
          end else if (r == RIW'(NUM_REGIONS - 1)) begin
            res_status <= ST_REJECT;
            state      <= S_RESP;
          end else begin
            r <= r + RIW'(1);
          end
        end

        S_AUTO_FIND: begin
          fs        <= (cur_b + align_m1) & ~align_m1;
          fe        <= cur_e & ~align_m1;
          e_r       <= cur_e;
          region_ok <= defined[r] && (AXW'(size_q) <= cur_len) && attr_ok;
          state     <= S_AUTO_CHK;
        end

        S_AUTO_CHK: begin
          if (region_ok && (fe > fs) && (AXW'(size_q) <= (fe - fs))) begin
            t     <= fs;
            phase <= PH_AUTO_N;
            state <= S_DIVGO;
          end else if (r == RIW'(NUM_REGIONS - 1)) begin
            res_status <= ST_REJECT;
            state      <= S_RESP;
          end else begin
            r     <= r + RIW'(1);
            state <= S_AUTO_FIND;
          end
        end

        S_DIVGO: state <= S_DIV;

        S_DIV: begin
          if (div_done) begin
            case (phase)
              PH_STAT_BS: begin
                bs_q  <= div_q;
                phase <= PH_STAT_N;
                state <= S_DIVGO;
              end
              PH_STAT_N: begin
                fill_lo    <= off + FW'(bs_g);
                fill_hi    <= off + FW'(stat_end);
                fill_v     <= 1'b1;
                res_status <= ST_OK;
                state      <= S_FILL_START;
              end
              PH_AUTO_N: begin
                n_g   <= GIW'(div_q);
                phase <= PH_AUTO_BS;
                state <= S_DIVGO;
              end
              default: begin
                bs_q  <= div_q;
                state <= S_CAND;
              end
            endcase
          end
        end

        S_CAND: begin
          if ((t < fe) && ((t + AXW'(size_q)) <= e_r) &&
              ((bs_q + AXW'(n_g)) <= AXW'(GRANULES_PER_REGION))) begin
            p     <= bs_g;
            state <= S_SCAN;
          end else if (r == RIW'(NUM_REGIONS - 1)) begin
            res_status <= ST_REJECT;
            state      <= S_RESP;
          end else begin
            r     <= r + RIW'(1);
            state <= S_AUTO_FIND;
          end
        end

        S_SCAN: begin
          if ((GIW+1)'(p) == win_end) begin
            fill_lo    <= off + FW'(bs_g);
            fill_hi    <= off + FW'(win_end);
            fill_v     <= 1'b1;
            res_status <= ST_OK;
            res_addr   <= t[31:0];
            state      <= S_FILL_START;
          end else if (buf_hit) begin
            if (!cur_bit) begin
              p <= p + GIW'(1);
            end else begin
              prod  <= (AXW'(p) + AXW'(1)) * AXW'(GRANULE_BYTES);
              state <= S_JUMP1;
            end
          end else begin
            state <= S_SCAN_LD;
          end
        end

        S_SCAN_LD: begin
          buf_word <= ram_rdata;
          buf_addr <= flat_word;
          buf_ok   <= 1'b1;
          state    <= S_SCAN;
        end

        // Skip to the first aligned candidate whose window starts past the
        // occupied granule.
        S_JUMP1: begin
          t     <= cur_b + prod;
          state <= S_JUMP2;
        end

        S_JUMP2: begin
          t     <= (t + align_m1) & ~align_m1;
          phase <= PH_AUTO_BS;
          state <= S_DIVGO;
        end

        S_FILL_START: begin
          widx  <= AW'(fill_lo >> WORD_LSB);
          wlast <= AW'((fill_hi - FW'(1)) >> WORD_LSB);
          state <= (fill_lo >= fill_hi) ? S_RESP : S_FILL_RD;
        end

        S_FILL_RD: state <= S_FILL_WR;

        S_FILL_WR: begin
          buf_ok <= 1'b0;
          if (widx == wlast) begin
            state <= S_RESP;
          end else begin
            widx  <= widx + AW'(1);
            state <= S_FILL_RD;
          end
        end

        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, res_addr, res_status};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Only an auto placement that succeeds reports an address.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[33:2] == 32'd0))
    else $error("nonzero address on a failed result");

  // The memory is written only by the clearing pass or a fill sweep.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_FILL_WR)))
    else $error("occupancy write outside a sweep");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("division result arrived unexpectedly");

  // No item is taken before the clearing pass is over.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("item accepted during memory clear");

  // The scan buffer is marked invalid by every fill write.
  assert property (@(posedge clk) disable iff (rst)
    $past(state == S_FILL_WR) |-> !buf_ok)
    else $error("scan buffer kept across a memory write");
`endif

endmodule

`default_nettype wire

FILE: verif/region_bitmap_placement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_bitmap_placement_tb
// Self-checking bench for the region table and first-fit placement block.
// ----------------------------------------------------------------------------
// Requests are built up front into a queue: a short directed list of edge
// cases, then about 1750 random define, static and automatic placement
// requests, with some malformed noise mixed in. Region sizes are kept small
// most of the time so that the serial search stays short. A behavioral copy
// of the region table and occupancy bitmaps predicts each result when its
// request is accepted. Each result is checked against the oldest prediction.
// Both stream sides stall at random in the first two of three phases.
// ----------------------------------------------------------------------------

module region_bitmap_placement_tb;
  import rbp_pkg::*;

  localparam int NREG    = NUM_REGIONS_DEF;
  localparam int NGRAN   = GRANULES_PER_REGION_DEF;
  localparam int GBYTES  = GRANULE_BYTES_DEF;
  localparam int N_RAND  = 1750;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  idx;
    logic [31:0] start;
    logic [32:0] size;
    logic [5:0]  attr;
    logic [4:0]  lg;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  region_bitmap_placement u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial forever #5 clk = ~clk;

  // Shadow of the block's region table and occupancy bitmaps.
  logic [31:0] tbl_base [NREG];
  logic [63:0] tbl_len  [NREG];
  logic [5:0]  tbl_attr [NREG];
  logic        tbl_def  [NREG];
  logic        occ [NREG][NGRAN];
  int unsigned free_run [NGRAN+1];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   taken = 0;
  int   total_reqs = 0;
  logic took = 1'b0;

  // Rough record of defined regions, used only to aim random requests.
  logic [31:0] aim_base [NREG];
  logic [31:0] aim_len  [NREG];

  function automatic void mark_granules(int r, logic [63:0] first, logic [63:0] cnt);
    for (logic [63:0] i = first; i < first + cnt && i < NGRAN; i++) occ[r][i] = 1'b1;
  endfunction

  function automatic logic [1:0] static_place(req_t q);
    logic [63:0] b, e, st, sz;
    st = q.start;
    sz = q.size;
    for (int r = 0; r < NREG; r++) begin
      if (!tbl_def[r]) continue;
      b = tbl_base[r];
      e = b + tbl_len[r];
      if (st >= b && st < e) begin
        if (st + sz > e) return ST_REJECT;
        if ((tbl_attr[r] & q.attr) != q.attr) return ST_REJECT;
        mark_granules(r, (st - b) / GBYTES, sz / GBYTES);
        return ST_OK;
      end
    end
    return ST_REJECT;
  endfunction

  function automatic res_t auto_place(req_t q);
    logic [63:0] align, b, e, fs, fe, t, n, bs, sz;
    res_t res;
    res = '{ST_REJECT, 32'd0};
    sz = q.size;
    align = 64'd1 << q.lg;
    for (int r = 0; r < NREG; r++) begin
      if (!tbl_def[r] || sz > tbl_len[r] || (tbl_attr[r] & q.attr) != q.attr) continue;
      b = tbl_base[r];
      e = b + tbl_len[r];
      fs = (b + align - 1) & ~(align - 1);
      fe = e & ~(align - 1);
      if (fe <= fs || sz > fe - fs) continue;
      // Running count of used granules, so a span test is one subtraction.
      free_run[0] = 0;
      for (int i = 0; i < NGRAN; i++) free_run[i+1] = free_run[i] + occ[r][i];
      n = sz / GBYTES;
      for (t = fs; t < fe && t + sz <= e; t += align) begin
        bs = (t - b) / GBYTES;
        if (bs + n > NGRAN) break;
        if (free_run[bs + n] == free_run[bs]) begin
          mark_granules(r, bs, n);
          res = '{ST_OK, t[31:0]};
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic res_t predict_result(req_t q);
    res_t res;
    res = '{ST_REJECT, 32'd0};
    case (q.mode)
      MODE_DEFINE: begin
        tbl_def[q.idx] = 1'b0;
        if (q.size > NGRAN * GBYTES) begin
          res.status = ST_TOO_BIG;
        end else if ({32'd0, q.start} + {31'd0, q.size} > 64'h1_0000_0000) begin
          res.status = ST_REJECT;
        end else begin
          tbl_base[q.idx] = q.start;
          tbl_len[q.idx]  = q.size;
          tbl_attr[q.idx] = q.attr;
          tbl_def[q.idx]  = 1'b1;
          for (int i = 0; i < NGRAN; i++) occ[q.idx][i] = 1'b0;
          res.status = ST_OK;
        end
      end
      MODE_STATIC: res.status = static_place(q);
      MODE_AUTO:   res = auto_place(q);
      default:     res.status = ST_REJECT;
    endcase
    return res;
  endfunction

  function automatic req_t mk(logic [1:0] m, logic [1:0] i, logic [31:0] s, logic [32:0] z,
                              logic [5:0] a, logic [4:0] l);
    req_t q;
    q = '{m, i, s, z, a, l};
    return q;
  endfunction

  // Random request generators; static requests are steered toward the regions defined so far.
  function automatic req_t rand_define();
    req_t q;
    int pick;
    q = mk(MODE_DEFINE, 2'($urandom_range(0, 3)), $urandom & ~32'h3,
           33'($urandom_range(0, 64) * GBYTES), 6'($urandom), 5'd0);
    pick = $urandom_range(0, 99);
    if (pick < 15) q.size = q.size + $urandom_range(1, 3);
    else if (pick < 17) q.size = 33'($urandom_range(1, NGRAN) * GBYTES);
    else if (pick < 20) q.size = 33'($urandom_range(NGRAN * GBYTES + 1, 1 << 20));
    else if (pick < 23) q.size = {1'($urandom), $urandom} | 33'h1_0000_0000;
    else if (pick < 26) q.start = 32'hFFFF_FFFF - $urandom_range(0, 300);
    if (pick > 90) q.lg = 5'($urandom);
    if (q.size <= NGRAN * GBYTES && {1'b0, q.start} + q.size <= 33'h1_0000_0000) begin
      aim_base[q.idx] = q.start;
      aim_len[q.idx]  = q.size[31:0];
    end
    return q;
  endfunction

  function automatic req_t rand_static();
    req_t q;
    int r;
    r = $urandom_range(0, 3);
    q = mk(MODE_STATIC, 2'($urandom), aim_base[r] + $urandom_range(0, aim_len[r]),
           33'($urandom_range(0, 16) * GBYTES), 6'($urandom) & 6'($urandom), 5'($urandom));
    if ($urandom_range(0, 9) == 0) q.size = q.size + $urandom_range(1, 3);
    if ($urandom_range(0, 19) == 0) q.start = $urandom;
    return q;
  endfunction

  function automatic req_t rand_auto();
    req_t q;
    q = mk(MODE_AUTO, 2'($urandom), $urandom, 33'($urandom_range(0, 12) * GBYTES),
           6'($urandom) & 6'($urandom) & 6'($urandom), 5'($urandom_range(0, 6)));
    if ($urandom_range(0, 9) == 0) q.size = q.size + $urandom_range(1, 3);
    if ($urandom_range(0, 19) == 0) q.lg = 5'($urandom);
    return q;
  endfunction

  initial begin
    int pick;
    for (int r = 0; r < NREG; r++) begin
      tbl_base[r] = '0; tbl_len[r] = '0; tbl_attr[r] = '0; tbl_def[r] = 1'b0;
      aim_base[r] = '0; aim_len[r] = 64;
      for (int i = 0; i < NGRAN; i++) occ[r][i] = 1'b0;
    end
    // Placement before any region exists, then the define corner cases.
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'd0, 33'd4, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd0, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd0, 32'h1000, 33'd256, 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd1, 32'h2000, 33'(NGRAN * GBYTES), 6'h05, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd2, 32'h0, 33'(NGRAN * GBYTES + 1), 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd2, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 6'h3F, 5'h1F));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd2, 32'hFFFF_FFF0, 33'd32, 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd2, 32'hFFFF_FF00, 33'd256, 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_DEFINE, 2'd3, 32'h8000, 33'd0, 6'h3F, 5'd0));
    // Static: fit, zero size, leaving the region, missing attribute, overlap, top of the address space.
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'h1000, 33'd64, 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'h1010, 33'd0, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'h10F0, 33'd32, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'h2004, 33'd8, 6'h02, 5'd0));
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'h1020, 33'd64, 6'd1, 5'd0));
    pending_reqs.push_back(mk(MODE_STATIC, 2'd0, 32'hFFFF_FFFC, 33'd4, 6'd0, 5'd0));
    // Auto: smallest and largest alignment, odd size, region too small.
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd16, 6'h3F, 5'd0));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd16, 6'd0, 5'd31));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd6, 6'd1, 5'd4));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd64, 6'h05, 5'd12));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'h1_0000_0000, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_AUTO, 2'd0, 32'd0, 33'd0, 6'd0, 5'd0));
    pending_reqs.push_back(mk(MODE_UNUSED, 2'd3, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 6'h3F, 5'h1F));
    pending_reqs.push_back(mk(MODE_UNUSED, 2'd0, 32'd0, 33'd0, 6'd0, 5'd0));
    for (int k = 0; k < N_RAND; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) pending_reqs.push_back(rand_define());
      else if (pick < 55) pending_reqs.push_back(rand_static());
      else if (pick < 95) pending_reqs.push_back(rand_auto());
      else pending_reqs.push_back(mk(2'($urandom), 2'($urandom), $urandom,
                                     {1'($urandom), $urandom}, 6'($urandom), 5'($urandom)));
    end
    total_reqs = pending_reqs.size();
  end

  // Stall odds per phase: sender idle, receiver idle.
  function automatic int send_idle_pct();
    if (taken < total_reqs / 3) return 22;
    if (taken < 2 * total_reqs / 3) return 68;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (taken < total_reqs / 3) return 68;
    if (taken < 2 * total_reqs / 3) return 22;
    return 0;
  endfunction

  // Request driver: changes inputs on the falling edge only.
  always @(negedge clk) begin
    req_t q;
    if (!rst && (!s_tvalid || took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        q = pending_reqs.pop_front();
        s_tdata  <= {2'b00, q.lg, q.attr, q.size, q.start, q.idx};
        s_tuser  <= q.mode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct());
  end

  // Acceptance and result checking on the rising edge.
  always @(posedge clk) begin
    req_t q;
    res_t want;
    took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      q = '{s_tuser, s_tdata[1:0], s_tdata[33:2], s_tdata[66:34], s_tdata[72:67],
            s_tdata[77:73]};
      expected_results.push_back(predict_result(q));
      taken <= taken + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: status %0d placed_address %h",
               m_tdata[1:0], m_tdata[33:2]);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[33:2] !== want.addr) begin
          $error("placed_address: expected %h, got %h", want.addr, m_tdata[33:2]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (total_reqs > 0);
    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[region_bitmap_placement] OK");
    end else begin
      $display("[region_bitmap_placement] ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("[region_bitmap_placement] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/rbp_pkg.sv
rtl/rbp_ram.sv
rtl/rbp_div.sv
rtl/region_bitmap_placement.sv
verif/region_bitmap_placement_tb.sv
